@@ rtl/b64u_pkg.sv @@
package b64u_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned SextetW = 6;
    localparam int unsigned CharW   = 7;
    localparam int unsigned PosW    = 2;
    localparam int unsigned CarryW  = 4;

    // position of the next byte inside its three-byte group
    localparam logic [PosW-1:0] POS_FIRST  = 2'd0;
    localparam logic [PosW-1:0] POS_SECOND = 2'd1;
    localparam logic [PosW-1:0] POS_THIRD  = 2'd2;

    localparam logic [CharW-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CharW-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CharW-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CharW-1:0] CHAR_DASH    = 7'h2d;
    localparam logic [CharW-1:0] CHAR_UNDER   = 7'h5f;

    typedef struct packed {
        logic [CharW-1:0]  char0;
        logic [CharW-1:0]  char1;
        logic              two;
        logic [PosW-1:0]   pos_next;
        logic [CarryW-1:0] carry_next;
    } enc_res_t;

    function automatic logic [CharW-1:0] sextet_char(input logic [SextetW-1:0] v);
        logic [CharW-1:0] idx;
        logic [CharW-1:0] c;
        idx = {1'b0, v};
        if (v < 6'd26)
            c = CHAR_UPPER_A + idx;
        else if (v < 6'd52)
            c = CHAR_LOWER_A + idx - 7'd26;
        else if (v < 6'd62)
            c = CHAR_ZERO + idx - 7'd52;
        else if (v == 6'd62)
            c = CHAR_DASH;
        else
            c = CHAR_UNDER;
        return c;
    endfunction

endpackage

@@ rtl/b64u_enc.sv @@
module b64u_enc
(
    input  logic [b64u_pkg::ByteW-1:0]  data_byte,
    input  logic                        last_byte,
    input  logic [b64u_pkg::PosW-1:0]   pos,
    input  logic [b64u_pkg::CarryW-1:0] carry,
    output b64u_pkg::enc_res_t          res
);
    import b64u_pkg::*;

    logic [SextetW-1:0] s0;
    logic [SextetW-1:0] s1;

    always_comb
    begin
        res = '0;
        case (pos)
            POS_SECOND:
            begin
                s0 = {carry[1:0], data_byte[7:4]};
                s1 = {data_byte[3:0], 2'b00};
                res.two        = last_byte;
                res.pos_next   = last_byte ? POS_FIRST : POS_THIRD;
                res.carry_next = last_byte ? '0 : data_byte[3:0];
            end
            POS_THIRD:
            begin
                s0 = {carry[3:0], data_byte[7:6]};
                s1 = data_byte[5:0];
                res.two        = 1'b1;
                res.pos_next   = POS_FIRST;
                res.carry_next = '0;
            end
            default:
            begin
                // the unused position code behaves as a group start
                s0 = data_byte[7:2];
                s1 = {data_byte[1:0], 4'b0000};
                res.two        = last_byte;
                res.pos_next   = last_byte ? POS_FIRST : POS_SECOND;
                res.carry_next = last_byte ? '0 : {2'b00, data_byte[1:0]};
            end
        endcase
        res.char0 = sextet_char(s0);
        res.char1 = sextet_char(s1);
    end

endmodule

@@ rtl/base64url_stream_encoder_core.sv @@
// channel | signals                       | direction | payload
// --------+-------------------------------+-----------+------------------------------------
// in      | in_valid / in_stall           | sink      | data_byte[7:0], last_byte
// out     | out_valid / out_stall         | source    | out_char[6:0], step_last, message_last
//
// a byte yields one character, or two (third byte of a group, or last byte of a
// message); the result register presents one character per cycle unless out stalls.
// sustained: 4 characters per 3 bytes. a byte passes the input register and then the
// result pair before its first character appears.
// rst_n clears group position, carried bits and all valid flags; no clearing pass.
// a stall on out holds the character; in stalls only when the result pair cannot drain.
module base64url_stream_encoder_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [b64u_pkg::ByteW-1:0] data_byte,
    input  logic                      last_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [b64u_pkg::CharW-1:0] out_char,
    output logic                      step_last,
    output logic                      message_last
);
    import b64u_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [ByteW-1:0]  s1_byte_reg;
    logic              s1_last_reg;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [CarryW-1:0] carry_reg, carry_next;
    logic              pair_valid_reg, pair_valid_next;
    logic              pair_two_reg, pair_two_next;
    logic [CharW-1:0]  char0_reg, char0_next;
    logic [CharW-1:0]  char1_reg, char1_next;
    logic              msg_last_reg, msg_last_next;

    logic     in_take;
    logic     out_take;
    logic     pair_free;
    logic     s1_move;
    enc_res_t enc;

    b64u_enc u_enc
    (
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .pos       (pos_reg),
        .carry     (carry_reg),
        .res       (enc)
    );

    assign out_take  = pair_valid_reg && !out_stall;
    // pair is free when empty or its final character leaves this cycle
    assign pair_free = !pair_valid_reg || (out_take && !pair_two_reg);
    assign s1_move   = s1_valid_reg && pair_free;
    assign in_stall  = s1_valid_reg && !pair_free;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        pos_next        = pos_reg;
        carry_next      = carry_reg;
        pair_valid_next = pair_valid_reg;
        pair_two_next   = pair_two_reg;
        char0_next      = char0_reg;
        char1_next      = char1_reg;
        msg_last_next   = msg_last_reg;

        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        if (s1_move)
        begin
            pos_next        = enc.pos_next;
            carry_next      = enc.carry_next;
            pair_valid_next = 1'b1;
            pair_two_next   = enc.two;
            char0_next      = enc.char0;
            char1_next      = enc.char1;
            msg_last_next   = s1_last_reg;
        end
        else if (out_take)
        begin
            if (pair_two_reg)
            begin
                char0_next    = char1_reg;
                pair_two_next = 1'b0;
            end
            else
                pair_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            pos_reg        <= POS_FIRST;
            carry_reg      <= '0;
            pair_valid_reg <= 1'b0;
            pair_two_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            pos_reg        <= pos_next;
            carry_reg      <= carry_next;
            pair_valid_reg <= pair_valid_next;
            pair_two_reg   <= pair_two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        char0_reg    <= char0_next;
        char1_reg    <= char1_next;
        msg_last_reg <= msg_last_next;
    end

    assign out_valid    = pair_valid_reg;
    assign out_char     = char0_reg;
    assign step_last    = !pair_two_reg;
    assign message_last = !pair_two_reg && msg_last_reg;

endmodule

@@ rtl/b64u_checker.sv @@
module b64u_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [b64u_pkg::CharW-1:0] out_char,
    input logic                       step_last,
    input logic                       message_last
);
    import b64u_pkg::*;

    // held character keeps its flags while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char)
            && $stable(step_last) && $stable(message_last))
        else $error("stalled character changed");

    a_msg_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_last |-> step_last)
        else $error("message end without request end");

    // second character of a request follows at once
    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !step_last |=> out_valid)
        else $error("second character missing");

    a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char >= 7'h41 && out_char <= 7'h5a)
            || (out_char >= 7'h61 && out_char <= 7'h7a)
            || (out_char >= 7'h30 && out_char <= 7'h39)
            || out_char == CHAR_DASH || out_char == CHAR_UNDER)
        else $error("character outside url-safe alphabet");

    // input only stalls behind a waiting character
    a_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind base64url_stream_encoder_core b64u_checker u_b64u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .step_last    (step_last),
    .message_last (message_last)
);
